// File: rtl/core/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types and constants for the camera container demux.
// ----------------------------------------------------------------------------
package ccd_pkg;

	localparam logic [31:0] SIG_FILE  = 32'h5356_5848; // "HXVS"
	localparam logic [31:0] SIG_AUDIO = 32'h4641_5848; // "HXAF"
	localparam logic [31:0] SIG_VIDEO = 32'h4656_5848; // "HXVF"
	localparam logic [31:0] SIG_END   = 32'h4946_5848; // "HXFI"

	localparam logic [4:0] NAL_SEI = 5'h06;
	localparam logic [4:0] NAL_SPS = 5'h07;
	localparam logic [4:0] NAL_PPS = 5'h08;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_CODE    = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_STAMP   = 3'd3,
		PH_SPARE   = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_STOPPED = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		K_AUDIO = 3'd0,
		K_VIDEO = 3'd1,
		K_ATS   = 3'd2,
		K_DUR   = 3'd3,
		K_END   = 3'd4,
		K_ERR   = 3'd5
	} kind_t;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_SIG  = 2'd1;
	localparam logic [1:0] ERR_BAD_CODE = 2'd2;

	// one queue entry: results caused by one input byte
	typedef struct packed {
		logic        prim_valid;
		kind_t       kind;
		logic [7:0]  payload;
		logic        vsv;
		logic [31:0] value;
		logic [1:0]  err;
		logic        end_valid;
		logic [31:0] end_value;
	} event_t;

endpackage

// File: rtl/core/camera_container_demux_unit.sv
// ----------------------------------------------------------------------------
// camera_container_demux_unit
// Camera recording demux: header check, record walk, audio/video split.
// ----------------------------------------------------------------------------
// Takes one recording byte per clock and turns it into zero, one or two
// result words (payload bytes, timestamps, duration, end, error). A byte is
// taken every cycle while the four-entry event queue has room; the output
// stage sends one word per cycle while m_axis_tready is high, so a byte that
// causes two words (a result plus the end-of-input word) is sent as two words
// in turn. Results pass through the event queue and then the output register.
module camera_container_demux_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tuser,  // start_of_file
	input  logic        s_axis_tlast,  // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // payload[7:0], value[39:8], error_code[41:40], 0
	output logic [3:0]  m_axis_tuser,  // kind[2:0], video_stamp_valid[3]
	output logic        m_axis_tlast   // last_of_run
);

	ccd_pkg::event_t ev;
	ccd_pkg::event_t head;
	ccd_pkg::kind_t  out_kind;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;
	logic            accept;
	logic [7:0]      out_payload;
	logic            out_vsv;
	logic [31:0]     out_value;
	logic [1:0]      out_err;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	ccd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_axis_tdata),
		.start_of_file (s_axis_tuser),
		.end_of_input  (s_axis_tlast),
		.push          (push),
		.ev            (ev)
	);

	ccd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (ev),
		.pop     (pop),
		.full    (full),
		.empty   (empty),
		.head    (head)
	);

	ccd_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_kind    (out_kind),
		.out_payload (out_payload),
		.out_vsv     (out_vsv),
		.out_value   (out_value),
		.out_err     (out_err),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, out_err, out_value, out_payload};
	assign m_axis_tuser = {out_vsv, out_kind};

endmodule

// File: rtl/core/ccd_parser.sv
// ----------------------------------------------------------------------------
// ccd_parser
// Front end: walks header and records one byte per accepted cycle, builds events.
// ----------------------------------------------------------------------------
module ccd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            start_of_file,
	input  logic            end_of_input,
	output logic            push,
	output ccd_pkg::event_t ev
);

	ccd_pkg::phase_t phase_q, cur_phase, nxt_phase;
	logic [3:0]  bif_q, cur_bif, nxt_bif;
	logic [31:0] code_q, cur_code, nxt_code;
	logic [31:0] len_q, cur_len, nxt_len;
	logic [31:0] rem_q, cur_rem, nxt_rem;
	logic [31:0] stamp_q, cur_stamp, nxt_stamp;
	logic [31:0] aorg_q, cur_aorg, nxt_aorg;
	logic        aov_q, cur_aov, nxt_aov;
	logic [31:0] vorg_q, cur_vorg, nxt_vorg;
	logic        vov_q, cur_vov, nxt_vov;
	logic [31:0] total_q, cur_total, nxt_total;
	logic [2:0]  vidx_q, cur_vidx, nxt_vidx;
	logic [31:0] lane;
	logic [31:0] code_or;
	logic [31:0] stamp_or;
	logic [31:0] aorg_use;
	logic [4:0]  nal;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ccd_pkg::PH_HEADER;
			bif_q   <= '0;
			code_q  <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			stamp_q <= '0;
			aorg_q  <= '0;
			aov_q   <= 1'b0;
			vorg_q  <= '0;
			vov_q   <= 1'b0;
			total_q <= '0;
			vidx_q  <= '0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			bif_q   <= nxt_bif;
			code_q  <= nxt_code;
			len_q   <= nxt_len;
			rem_q   <= nxt_rem;
			stamp_q <= nxt_stamp;
			aorg_q  <= nxt_aorg;
			aov_q   <= nxt_aov;
			vorg_q  <= nxt_vorg;
			vov_q   <= nxt_vov;
			total_q <= nxt_total;
			vidx_q  <= nxt_vidx;
		end
	end

	always_comb begin
		if (start_of_file) begin
			cur_phase = ccd_pkg::PH_HEADER;
			cur_bif   = '0;
			cur_code  = '0;
			cur_len   = '0;
			cur_rem   = '0;
			cur_stamp = '0;
			cur_aorg  = '0;
			cur_aov   = 1'b0;
			cur_vorg  = '0;
			cur_vov   = 1'b0;
			cur_total = '0;
			cur_vidx  = '0;
		end else begin
			cur_phase = phase_q;
			cur_bif   = bif_q;
			cur_code  = code_q;
			cur_len   = len_q;
			cur_rem   = rem_q;
			cur_stamp = stamp_q;
			cur_aorg  = aorg_q;
			cur_aov   = aov_q;
			cur_vorg  = vorg_q;
			cur_vov   = vov_q;
			cur_total = total_q;
			cur_vidx  = vidx_q;
		end

		nxt_phase = cur_phase;
		nxt_bif   = cur_bif;
		nxt_code  = cur_code;
		nxt_len   = cur_len;
		nxt_rem   = cur_rem;
		nxt_stamp = cur_stamp;
		nxt_aorg  = cur_aorg;
		nxt_aov   = cur_aov;
		nxt_vorg  = cur_vorg;
		nxt_vov   = cur_vov;
		nxt_total = cur_total;
		nxt_vidx  = cur_vidx;

		lane     = {24'd0, data_byte} << {cur_bif[1:0], 3'b000};
		code_or  = cur_code | lane;
		stamp_or = cur_stamp | lane;
		aorg_use = cur_aov ? cur_aorg : stamp_or;
		nal      = data_byte[4:0];
		ev       = '0;

		unique case (cur_phase)
			ccd_pkg::PH_HEADER: begin
				if (cur_bif < 4'd4)
					nxt_code = code_or;
				if (cur_bif == 4'd3 && code_or != ccd_pkg::SIG_FILE) begin
					ev.prim_valid = 1'b1;
					ev.kind       = ccd_pkg::K_ERR;
					ev.err        = ccd_pkg::ERR_BAD_SIG;
					nxt_phase     = ccd_pkg::PH_STOPPED;
				end else begin
					if (cur_bif >= 4'd8 && cur_bif <= 4'd11)
						nxt_stamp = stamp_or;
					if (cur_bif == 4'd11) begin
						ev.prim_valid = 1'b1;
						ev.kind       = ccd_pkg::K_DUR;
						ev.value      = stamp_or;
					end
					if (cur_bif == 4'd15) begin
						nxt_phase = ccd_pkg::PH_CODE;
						nxt_bif   = '0;
						nxt_code  = '0;
					end else begin
						nxt_bif = cur_bif + 4'd1;
					end
				end
			end
			ccd_pkg::PH_CODE: begin
				nxt_code = code_or;
				if (cur_bif[1:0] == 2'd3) begin
					if (code_or == ccd_pkg::SIG_END) begin
						ev.prim_valid = 1'b1;
						ev.kind       = ccd_pkg::K_END;
						ev.value      = cur_total;
						nxt_phase     = ccd_pkg::PH_STOPPED;
					end else begin
						nxt_phase = ccd_pkg::PH_LENGTH;
						nxt_bif   = '0;
						nxt_len   = '0;
					end
				end else begin
					nxt_bif = {2'b00, cur_bif[1:0]} + 4'd1;
				end
			end
			ccd_pkg::PH_LENGTH: begin
				nxt_len = cur_len | lane;
				if (cur_bif[1:0] == 2'd3) begin
					if (cur_code == ccd_pkg::SIG_AUDIO || cur_code == ccd_pkg::SIG_VIDEO) begin
						nxt_phase = ccd_pkg::PH_STAMP;
						nxt_bif   = '0;
						nxt_stamp = '0;
					end else begin
						ev.prim_valid = 1'b1;
						ev.kind       = ccd_pkg::K_ERR;
						ev.err        = ccd_pkg::ERR_BAD_CODE;
						nxt_phase     = ccd_pkg::PH_CODE;
						nxt_bif       = '0;
						nxt_code      = '0;
					end
				end else begin
					nxt_bif = {2'b00, cur_bif[1:0]} + 4'd1;
				end
			end
			ccd_pkg::PH_STAMP: begin
				nxt_stamp = stamp_or;
				if (cur_bif[1:0] == 2'd3) begin
					if (cur_code == ccd_pkg::SIG_AUDIO) begin
						nxt_aorg      = aorg_use;
						nxt_aov       = 1'b1;
						ev.prim_valid = 1'b1;
						ev.kind       = ccd_pkg::K_ATS;
						ev.value      = stamp_or - aorg_use;
					end else if (!cur_vov) begin
						nxt_vorg = stamp_or;
						nxt_vov  = 1'b1;
					end
					nxt_phase = ccd_pkg::PH_SPARE;
					nxt_bif   = '0;
				end else begin
					nxt_bif = {2'b00, cur_bif[1:0]} + 4'd1;
				end
			end
			ccd_pkg::PH_SPARE: begin
				if (cur_bif[1:0] == 2'd3) begin
					nxt_rem  = cur_len;
					nxt_bif  = '0;
					nxt_vidx = '0;
					if (cur_len == '0) begin
						nxt_phase = ccd_pkg::PH_CODE;
						nxt_code  = '0;
					end else begin
						nxt_phase = ccd_pkg::PH_PAYLOAD;
					end
				end else begin
					nxt_bif = {2'b00, cur_bif[1:0]} + 4'd1;
				end
			end
			ccd_pkg::PH_PAYLOAD: begin
				nxt_rem = cur_rem - 32'd1;
				if (cur_code == ccd_pkg::SIG_AUDIO) begin
					if (cur_bif < 4'd4) begin
						nxt_bif = cur_bif + 4'd1;
					end else begin
						ev.prim_valid = 1'b1;
						ev.kind       = ccd_pkg::K_AUDIO;
						ev.payload    = data_byte;
						nxt_total     = cur_total + 32'd1;
					end
				end else begin
					if (cur_vidx < 3'd5)
						nxt_vidx = cur_vidx + 3'd1;
					ev.prim_valid = 1'b1;
					ev.kind       = ccd_pkg::K_VIDEO;
					ev.payload    = data_byte;
					if (cur_vidx == 3'd4 && nal != ccd_pkg::NAL_SEI
							&& nal != ccd_pkg::NAL_SPS && nal != ccd_pkg::NAL_PPS) begin
						ev.vsv   = 1'b1;
						ev.value = cur_stamp - cur_vorg;
					end
				end
				if (nxt_rem == '0) begin
					nxt_phase = ccd_pkg::PH_CODE;
					nxt_bif   = '0;
					nxt_code  = '0;
				end
			end
			default: begin
				nxt_phase = ccd_pkg::PH_STOPPED;
			end
		endcase

		if (end_of_input && nxt_phase != ccd_pkg::PH_STOPPED) begin
			ev.end_valid = 1'b1;
			ev.end_value = nxt_total;
			nxt_phase    = ccd_pkg::PH_STOPPED;
		end

		push = accept && (ev.prim_valid || ev.end_valid);
	end

endmodule

// File: rtl/core/ccd_queue.sv
// ----------------------------------------------------------------------------
// ccd_queue
// Small event queue between parser and output stage.
// ----------------------------------------------------------------------------
module ccd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ccd_pkg::event_t push_ev,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output ccd_pkg::event_t head
);

	ccd_pkg::event_t mem_q [ccd_pkg::QDepth];
	logic [ccd_pkg::QPtrW-1:0] wptr_q;
	logic [ccd_pkg::QPtrW-1:0] rptr_q;
	logic [ccd_pkg::QCntW-1:0] cnt_q;

	assign full  = (cnt_q == ccd_pkg::QCntW'(ccd_pkg::QDepth));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + ccd_pkg::QPtrW'(1);
			if (pop)
				rptr_q <= rptr_q + ccd_pkg::QPtrW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + ccd_pkg::QCntW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - ccd_pkg::QCntW'(1);
		end
	end

endmodule

// File: rtl/core/ccd_emitter.sv
// ----------------------------------------------------------------------------
// ccd_emitter
// Back end: expands queued events into output words through a register.
// ----------------------------------------------------------------------------
module ccd_emitter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  ccd_pkg::event_t head,
	output logic            pop,
	input  logic            out_ready,
	output logic            out_valid,
	output ccd_pkg::kind_t  out_kind,
	output logic [7:0]      out_payload,
	output logic            out_vsv,
	output logic [31:0]     out_value,
	output logic [1:0]      out_err,
	output logic            out_last
);

	logic valid_q;
	logic second_q;
	logic load;
	logic take_prim;
	logic word_last;

	// second_q: primary already sent, end word still pending
	assign load      = !valid_q || out_ready;
	assign take_prim = head.prim_valid && !second_q;
	assign word_last = take_prim ? !head.end_valid : 1'b1;
	assign pop       = load && !empty && word_last;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty)
				second_q <= !word_last;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (take_prim) begin
				out_kind    <= head.kind;
				out_payload <= head.payload;
				out_vsv     <= head.vsv;
				out_value   <= head.value;
				out_err     <= head.err;
			end else begin
				out_kind    <= ccd_pkg::K_END;
				out_payload <= '0;
				out_vsv     <= 1'b0;
				out_value   <= head.end_value;
				out_err     <= ccd_pkg::ERR_NONE;
			end
			out_last <= word_last;
		end
	end

endmodule

// File: rtl/core/ccd_checker.sv
// ----------------------------------------------------------------------------
// ccd_checker
// Port-level checks for the camera container demux, bound to the top level.
// ----------------------------------------------------------------------------
module ccd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[41:40] != ccd_pkg::ERR_NONE)
			== (m_axis_tuser[2:0] == ccd_pkg::K_ERR)))
		else $error("error code does not match word kind");

	a_payload_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] != ccd_pkg::K_AUDIO
			&& m_axis_tuser[2:0] != ccd_pkg::K_VIDEO |-> m_axis_tdata[7:0] == 8'd0)
		else $error("payload set on non-data word");

	a_stamp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == ccd_pkg::K_VIDEO)
		else $error("video stamp flag on non-video word");

endmodule

bind camera_container_demux_unit ccd_checker u_ccd_checker (.*);
